### rtl/eiuhp_pkg.sv
package eiuhp_pkg;

    // ethertypes with the first wire byte in the low 8 bits
    localparam logic [15:0] ETYPE_IPV4 = 16'h0008;
    localparam logic [15:0] ETYPE_IPV6 = 16'hDD86;
    localparam logic [15:0] ETYPE_LLDP = 16'hCC88;

    // ip next header codes
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_NONE = 8'd59;

    // frame kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_UDP   = 2'd1;
    localparam logic [1:0] KIND_LLDP  = 2'd2;

    // ip families
    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_IPV4 = 2'd1;
    localparam logic [1:0] FAM_IPV6 = 2'd2;

    // header lengths and fixed offsets
    localparam logic [15:0] ETH_LEN      = 16'd14;
    localparam logic [15:0] IPV4_LEN     = 16'd20;
    localparam logic [15:0] IPV6_LEN     = 16'd40;
    localparam logic [15:0] LLDP_LEN     = 16'd2;
    localparam logic [15:0] UDP_LEN      = 16'd8;
    localparam logic [15:0] LLDP_PAY_OFS = 16'd16;
    localparam logic [15:0] OFS_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        STG_ETH,
        STG_IPV4,
        STG_IPV6,
        STG_EXT,
        STG_UDP,
        STG_LLDP,
        STG_DONE
    } t_stage;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [1:0]  ip_family;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } t_out;

    // last byte of a header starting at start with len bytes, saturated
    function automatic logic [15:0] sect_end(input logic [15:0] start,
                                             input logic [15:0] len);
        logic [16:0] sum;
        sum = {1'b0, start} + {1'b0, len} - 17'd1;
        return sum[16] ? OFS_MAX : sum[15:0];
    endfunction

endpackage

### rtl/ethernet_ip_udp_header_parser_core.sv
// a result is registered from the transaction carrying the last byte, valid in the next cycle
// throughput: one frame byte per cycle; bytes that are not the last are taken even
// while a result waits, the last byte waits for the output register to free up
// header state updates in one pass between the input handshake and the result register
// reset (synchronous, active low) returns the parser to the ethernet stage, no result held
module ethernet_ip_udp_header_parser_core
    import eiuhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // per-frame state
    t_stage      r_stage,       n_stage;
    logic [15:0] r_offset,      n_offset;
    logic [7:0]  r_etype_lo,    n_etype_lo;
    logic [7:0]  r_next_header, n_next_header;
    logic [15:0] r_section_end, n_section_end;
    logic [15:0] r_udp_start,   n_udp_start;
    logic [63:0] r_src_hi,      n_src_hi;
    logic [63:0] r_src_lo,      n_src_lo;
    logic [63:0] r_dst_hi,      n_dst_hi;
    logic [63:0] r_dst_lo,      n_dst_lo;
    logic [15:0] r_src_port,    n_src_port;
    logic [15:0] r_dst_port,    n_dst_port;
    logic [1:0]  r_kind,        n_kind;
    logic [1:0]  r_family,      n_family;

    // result register
    logic        r_out_valid;
    t_out        r_out;
    t_out        n_result;

    logic        in_xact;
    logic [15:0] idx;
    logic [15:0] rel;
    logic [7:0]  b;
    logic [15:0] etype;
    logic [15:0] ext_len;
    logic [15:0] pay_ofs;
    logic        at_end;

    assign o_in_ready  = !r_out_valid || i_out_ready || !i_in_data.last_byte;
    assign in_xact     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx     = r_offset;
    assign rel     = r_offset - r_udp_start;
    assign b       = i_in_data.frame_byte;
    assign etype   = {b, r_etype_lo};
    assign ext_len = UDP_LEN + {5'd0, b, 3'd0};
    assign at_end  = (idx == r_section_end);

    // header walk for one byte and result assembly on the last byte
    always_comb begin
        n_stage       = r_stage;
        n_offset      = r_offset;
        n_etype_lo    = r_etype_lo;
        n_next_header = r_next_header;
        n_section_end = r_section_end;
        n_udp_start   = r_udp_start;
        n_src_hi      = r_src_hi;
        n_src_lo      = r_src_lo;
        n_dst_hi      = r_dst_hi;
        n_dst_lo      = r_dst_lo;
        n_src_port    = r_src_port;
        n_dst_port    = r_dst_port;
        n_kind        = r_kind;
        n_family      = r_family;
        pay_ofs       = '0;
        n_result      = '0;

        if (r_offset != OFS_MAX) begin
            n_offset = r_offset + 16'd1;
            case (r_stage)
                STG_ETH: begin
                    if (idx == 16'd12) begin
                        n_etype_lo = b;
                    end else if (idx == 16'd13) begin
                        n_udp_start = ETH_LEN;
                        if (etype == ETYPE_IPV4) begin
                            n_stage       = STG_IPV4;
                            n_section_end = sect_end(ETH_LEN, IPV4_LEN);
                        end else if (etype == ETYPE_IPV6) begin
                            n_stage       = STG_IPV6;
                            n_section_end = sect_end(ETH_LEN, IPV6_LEN);
                        end else if (etype == ETYPE_LLDP) begin
                            n_stage       = STG_LLDP;
                            n_section_end = sect_end(ETH_LEN, LLDP_LEN);
                        end else begin
                            n_stage     = STG_DONE;
                            n_udp_start = r_udp_start;
                        end
                    end
                end
                STG_IPV4: begin
                    if (rel == 16'd9) begin
                        n_next_header = b;
                    end else if (rel >= 16'd12 && rel <= 16'd15) begin
                        {n_src_hi, n_src_lo} = {r_src_hi[55:0], r_src_lo, b};
                    end else if (rel >= 16'd16 && rel <= 16'd19) begin
                        {n_dst_hi, n_dst_lo} = {r_dst_hi[55:0], r_dst_lo, b};
                    end
                    if (at_end) begin
                        n_family = FAM_IPV4;
                        if (r_next_header == PROTO_UDP) begin
                            n_stage       = STG_UDP;
                            n_udp_start   = idx + 16'd1;
                            n_section_end = sect_end(idx + 16'd1, UDP_LEN);
                        end else begin
                            n_stage = STG_DONE;
                        end
                    end
                end
                STG_IPV6, STG_EXT: begin
                    if (r_stage == STG_IPV6) begin
                        if (rel == 16'd6) begin
                            n_next_header = b;
                        end else if (rel >= 16'd8 && rel <= 16'd23) begin
                            {n_src_hi, n_src_lo} = {r_src_hi[55:0], r_src_lo, b};
                        end else if (rel >= 16'd24 && rel <= 16'd39) begin
                            {n_dst_hi, n_dst_lo} = {r_dst_hi[55:0], r_dst_lo, b};
                        end
                        if (at_end) begin
                            n_family = FAM_IPV6;
                        end
                    end else begin
                        if (rel == 16'd0) begin
                            n_next_header = b;
                        end else if (rel == 16'd1) begin
                            n_section_end = sect_end(r_udp_start, ext_len);
                        end
                    end
                    // a header end never falls on its first two bytes
                    if (at_end) begin
                        if (r_next_header == PROTO_UDP) begin
                            n_stage       = STG_UDP;
                            n_udp_start   = idx + 16'd1;
                            n_section_end = sect_end(idx + 16'd1, UDP_LEN);
                        end else if (r_next_header == PROTO_NONE) begin
                            n_stage = STG_DONE;
                        end else begin
                            n_stage       = STG_EXT;
                            n_udp_start   = idx + 16'd1;
                            n_section_end = sect_end(idx + 16'd1, UDP_LEN);
                        end
                    end
                end
                STG_UDP: begin
                    if (rel <= 16'd1) begin
                        n_src_port = {r_src_port[7:0], b};
                    end else if (rel <= 16'd3) begin
                        n_dst_port = {r_dst_port[7:0], b};
                    end
                    if (at_end) begin
                        n_kind  = KIND_UDP;
                        n_stage = STG_DONE;
                    end
                end
                STG_LLDP: begin
                    if (at_end) begin
                        n_kind  = KIND_LLDP;
                        n_stage = STG_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // result from the updated state
        n_result.frame_kind = n_kind;
        n_result.ip_family  = n_family;
        if (n_family != FAM_NONE) begin
            n_result.source_addr_high = n_src_hi;
            n_result.source_addr_low  = n_src_lo;
            n_result.dest_addr_high   = n_dst_hi;
            n_result.dest_addr_low    = n_dst_lo;
        end
        if (n_kind == KIND_UDP) begin
            pay_ofs                 = n_udp_start + UDP_LEN;
            n_result.source_port    = n_src_port;
            n_result.dest_port      = n_dst_port;
            n_result.payload_offset = pay_ofs;
            n_result.payload_length = (n_offset >= pay_ofs) ? (n_offset - pay_ofs) : '0;
        end else if (n_kind == KIND_LLDP) begin
            n_result.payload_offset = ETH_LEN;
            n_result.payload_length = (n_offset >= LLDP_PAY_OFS) ?
                                      (n_offset - LLDP_PAY_OFS) : '0;
        end
    end

    // control state and per-frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_xact && i_in_data.last_byte)) begin
            r_stage       <= STG_ETH;
            r_offset      <= '0;
            r_etype_lo    <= '0;
            r_next_header <= '0;
            r_section_end <= '0;
            r_udp_start   <= '0;
            r_src_hi      <= '0;
            r_src_lo      <= '0;
            r_dst_hi      <= '0;
            r_dst_lo      <= '0;
            r_src_port    <= '0;
            r_dst_port    <= '0;
            r_kind        <= KIND_OTHER;
            r_family      <= FAM_NONE;
        end else if (in_xact) begin
            r_stage       <= n_stage;
            r_offset      <= n_offset;
            r_etype_lo    <= n_etype_lo;
            r_next_header <= n_next_header;
            r_section_end <= n_section_end;
            r_udp_start   <= n_udp_start;
            r_src_hi      <= n_src_hi;
            r_src_lo      <= n_src_lo;
            r_dst_hi      <= n_dst_hi;
            r_dst_lo      <= n_dst_lo;
            r_src_port    <= n_src_port;
            r_dst_port    <= n_dst_port;
            r_kind        <= n_kind;
            r_family      <= n_family;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xact && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_xact && i_in_data.last_byte) begin
            r_out <= n_result;
        end
    end

endmodule

### sim/eiuhp_result_checker.sv
module eiuhp_result_checker
    import eiuhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFS_LIMIT   = 65535;
    localparam int EXT_UNIT    = 8;

    // header walk state for the frame in flight
    logic [15:0]  byte_pos;
    t_stage       stage;
    logic [15:0]  etype;
    logic [7:0]   nxt_hdr;
    int           hdr_first;
    int           hdr_last;
    logic [127:0] src_addr;
    logic [127:0] dst_addr;
    logic [15:0]  sport;
    logic [15:0]  dport;
    logic [1:0]   kind;
    logic [1:0]   fam;

    // frame summaries waiting for their result transaction
    t_out frame_summaries[$];
    int   fail_cnt = 0;
    int   pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // index of the last byte of a header, pinned at the offset ceiling
    function automatic int clip_end(int start, int len);
        int v;
        v = start + len - 1;
        return (v > OFS_LIMIT) ? OFS_LIMIT : v;
    endfunction

    task automatic clear_frame_state();
        byte_pos  = '0;
        stage     = STG_ETH;
        etype     = '0;
        nxt_hdr   = '0;
        hdr_first = 0;
        hdr_last  = 0;
        src_addr  = '0;
        dst_addr  = '0;
        sport     = '0;
        dport     = '0;
        kind      = KIND_OTHER;
        fam       = FAM_NONE;
    endtask

    task automatic open_hdr(t_stage s, int start, int len);
        stage     = s;
        hdr_first = start;
        hdr_last  = clip_end(start, len);
    endtask

    // what follows an ipv6 header or an extension
    task automatic follow_next(int idx);
        if (nxt_hdr == PROTO_UDP) begin
            open_hdr(STG_UDP, idx + 1, int'(UDP_LEN));
        end else if (nxt_hdr == PROTO_NONE) begin
            stage = STG_DONE;
        end else begin
            open_hdr(STG_EXT, idx + 1, EXT_UNIT);
        end
    endtask

    task automatic take_header_byte(int idx, logic [7:0] b);
        int rel;
        rel = idx - hdr_first;
        case (stage)
            STG_ETH: begin
                if (idx == 12) begin
                    etype = {8'h00, b};
                end else if (idx == 13) begin
                    etype[15:8] = b;
                    if (etype == ETYPE_IPV4) begin
                        open_hdr(STG_IPV4, int'(ETH_LEN), int'(IPV4_LEN));
                    end else if (etype == ETYPE_IPV6) begin
                        open_hdr(STG_IPV6, int'(ETH_LEN), int'(IPV6_LEN));
                    end else if (etype == ETYPE_LLDP) begin
                        open_hdr(STG_LLDP, int'(ETH_LEN), int'(LLDP_LEN));
                    end else begin
                        stage = STG_DONE;
                    end
                end
            end
            STG_IPV4: begin
                if (rel == 9) begin
                    nxt_hdr = b;
                end else if (rel >= 12 && rel <= 15) begin
                    src_addr = {src_addr[119:0], b};
                end else if (rel >= 16 && rel <= 19) begin
                    dst_addr = {dst_addr[119:0], b};
                end
                if (idx == hdr_last) begin
                    fam = FAM_IPV4;
                    if (nxt_hdr == PROTO_UDP) begin
                        open_hdr(STG_UDP, idx + 1, int'(UDP_LEN));
                    end else begin
                        stage = STG_DONE;
                    end
                end
            end
            STG_IPV6: begin
                if (rel == 6) begin
                    nxt_hdr = b;
                end else if (rel >= 8 && rel <= 23) begin
                    src_addr = {src_addr[119:0], b};
                end else if (rel >= 24 && rel <= 39) begin
                    dst_addr = {dst_addr[119:0], b};
                end
                if (idx == hdr_last) begin
                    fam = FAM_IPV6;
                    follow_next(idx);
                end
            end
            STG_EXT: begin
                if (rel == 0) begin
                    nxt_hdr = b;
                end else if (rel == 1) begin
                    hdr_last = clip_end(hdr_first, EXT_UNIT + EXT_UNIT * int'(b));
                end
                if (idx == hdr_last) begin
                    follow_next(idx);
                end
            end
            STG_UDP: begin
                if (rel <= 1) begin
                    sport = {sport[7:0], b};
                end else if (rel <= 3) begin
                    dport = {dport[7:0], b};
                end
                if (idx == hdr_last) begin
                    kind  = KIND_UDP;
                    stage = STG_DONE;
                end
            end
            STG_LLDP: begin
                if (idx == hdr_last) begin
                    kind  = KIND_LLDP;
                    stage = STG_DONE;
                end
            end
            default: begin
            end
        endcase
    endtask

    // advance the walk by one byte, summarize the frame on its last byte
    task automatic predict_byte(t_in item);
        t_out r;
        int   len;
        int   po;
        if (byte_pos != OFS_MAX) begin
            take_header_byte(int'(byte_pos), item.frame_byte);
            byte_pos++;
        end
        if (item.last_byte) begin
            r = '0;
            len = int'(byte_pos);
            r.frame_kind = kind;
            r.ip_family  = fam;
            if (fam != FAM_NONE) begin
                r.source_addr_high = src_addr[127:64];
                r.source_addr_low  = src_addr[63:0];
                r.dest_addr_high   = dst_addr[127:64];
                r.dest_addr_low    = dst_addr[63:0];
            end
            if (kind == KIND_UDP) begin
                po = hdr_first + int'(UDP_LEN);
                r.source_port    = sport;
                r.dest_port      = dport;
                r.payload_offset = po[15:0];
                r.payload_length = (len >= po) ? 16'(len - po) : '0;
            end else if (kind == KIND_LLDP) begin
                r.payload_offset = ETH_LEN;
                r.payload_length = (len >= int'(LLDP_PAY_OFS)) ?
                                   16'(len - int'(LLDP_PAY_OFS)) : '0;
            end
            frame_summaries.push_back(r);
            pending_cnt++;
            clear_frame_state();
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_cnt++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    task automatic compare_result(t_out got);
        t_out want;
        if (frame_summaries.size() == 0) begin
            fail_cnt++;
            $error("result transaction with no frame outstanding");
        end else begin
            want = frame_summaries.pop_front();
            pending_cnt--;
            check_field("frame_kind", 64'(want.frame_kind), 64'(got.frame_kind));
            check_field("ip_family", 64'(want.ip_family), 64'(got.ip_family));
            check_field("source_addr_high", want.source_addr_high, got.source_addr_high);
            check_field("source_addr_low", want.source_addr_low, got.source_addr_low);
            check_field("dest_addr_high", want.dest_addr_high, got.dest_addr_high);
            check_field("dest_addr_low", want.dest_addr_low, got.dest_addr_low);
            check_field("source_port", 64'(want.source_port), 64'(got.source_port));
            check_field("dest_port", 64'(want.dest_port), 64'(got.dest_port));
            check_field("payload_offset", 64'(want.payload_offset),
                        64'(got.payload_offset));
            check_field("payload_length", 64'(want.payload_length),
                        64'(got.payload_length));
        end
    endtask

    // results are checked before the byte of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame_state();
            frame_summaries.delete();
            pending_cnt = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_result(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in_data);
            end
        end
    end

endmodule

### sim/ethernet_ip_udp_header_parser_core_tb.sv
module ethernet_ip_udp_header_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eiuhp_pkg::*;

    localparam int RUN_LIMIT     = 800_000;
    localparam int IDLE_PCT      = 14;
    localparam int RANDOM_BYTES  = 1350;
    localparam int RANDOM_FRAMES = 20;
    localparam int TAIL_CYCLES   = 8;

    // next header codes used beside udp and no-next-header
    localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] NH_ROUTING    = 8'd43;
    localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    int         fail_count;
    int         pending;
    int         cycle_cnt = 0;
    logic       steady = 1'b0;
    t_fill      fill_mode = FILL_RANDOM;
    logic [7:0] frame_q[$];
    int         bytes_sent = 0;
    int         frames_sent = 0;

    ethernet_ip_udp_header_parser_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    eiuhp_result_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("ethernet_ip_udp_header_parser_core: mismatch");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [7:0] fill_byte();
        case (fill_mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    // extension code that keeps the walk going
    function automatic logic [7:0] ext_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (c == PROTO_UDP || c == PROTO_NONE);
        return c;
    endfunction

    // mostly short extensions, now and then a longer one
    function automatic logic [7:0] ext_len();
        return ($urandom_range(99) < 95) ? 8'($urandom_range(2)) : 8'($urandom_range(31, 3));
    endfunction

    task automatic add_fill(int n);
        repeat (n) frame_q.push_back(fill_byte());
    endtask

    task automatic add_eth(logic [15:0] et);
        add_fill(12);
        frame_q.push_back(et[7:0]);
        frame_q.push_back(et[15:8]);
    endtask

    task automatic add_ipv4(logic [7:0] proto);
        for (int k = 0; k < int'(IPV4_LEN); k++) begin
            frame_q.push_back((k == 9) ? proto : fill_byte());
        end
    endtask

    task automatic add_ipv6(logic [7:0] nh);
        for (int k = 0; k < int'(IPV6_LEN); k++) begin
            frame_q.push_back((k == 6) ? nh : fill_byte());
        end
    endtask

    task automatic add_ext(logic [7:0] nh, logic [7:0] len);
        frame_q.push_back(nh);
        frame_q.push_back(len);
        add_fill(6 + 8 * int'(len));
    endtask

    task automatic add_udp();
        add_fill(int'(UDP_LEN));
    endtask

    // one byte transaction, random idle cycles ahead of it
    task automatic push_byte(logic [7:0] b, logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{frame_byte: b, last_byte: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // send the first cut bytes of the built frame, mark the final one
    task automatic send_frame(int cut);
        for (int k = 0; k < cut; k++) begin
            push_byte(frame_q[k], k == cut - 1);
        end
        frame_q.delete();
        frames_sent++;
    endtask

    task automatic send_whole();
        send_frame(frame_q.size());
    endtask

    // hold off until every result is in
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_frame();
        int         pick;
        int         n_ext;
        int         cut;
        logic [7:0] nh;
        logic [7:0] last_nh;
        logic [15:0] et;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // ipv4, mostly udp
            nh = ($urandom_range(99) < 80) ? PROTO_UDP : 8'($urandom);
            add_eth(ETYPE_IPV4);
            add_ipv4(nh);
            if (nh == PROTO_UDP) begin
                add_udp();
            end
            add_fill($urandom_range(12));
        end else if (pick < 62) begin
            // ipv6 with an optional extension chain
            n_ext = ($urandom_range(99) < 50) ? 0 : $urandom_range(3, 1);
            pick = $urandom_range(99);
            if (pick < 75) begin
                last_nh = PROTO_UDP;
            end else if (pick < 90) begin
                last_nh = PROTO_NONE;
            end else begin
                last_nh = ext_code();
            end
            add_eth(ETYPE_IPV6);
            add_ipv6((n_ext == 0) ? last_nh : ext_code());
            for (int k = 0; k < n_ext; k++) begin
                add_ext((k == n_ext - 1) ? last_nh : ext_code(), ext_len());
            end
            if (last_nh == PROTO_UDP) begin
                add_udp();
            end
            add_fill($urandom_range(12));
        end else if (pick < 75) begin
            add_eth(ETYPE_LLDP);
            add_fill($urandom_range(20));
        end else if (pick < 87) begin
            // unknown ethertype, half of them one bit off a known one
            if ($urandom_range(1) == 0) begin
                et = 16'($urandom);
            end else begin
                case ($urandom_range(2))
                    0:       et = ETYPE_IPV4;
                    1:       et = ETYPE_IPV6;
                    default: et = ETYPE_LLDP;
                endcase
                et = et ^ (16'd1 << $urandom_range(15));
            end
            add_eth(et);
            add_fill($urandom_range(20));
        end else begin
            add_fill($urandom_range(60, 1));
        end
        cut = ($urandom_range(99) < 15) ? $urandom_range(frame_q.size(), 1) : frame_q.size();
        send_frame(cut);
    endtask

    initial begin
        int rand_bytes0;
        int rand_frames0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single byte frame
        fill_mode = FILL_ONES;
        frame_q.push_back(8'hFF);
        send_whole();
        // frame ends inside the ethertype
        fill_mode = FILL_ZERO;
        add_fill(13);
        send_whole();
        // unknown ethertype
        fill_mode = FILL_ONES;
        add_eth(16'hFFFF);
        add_fill(4);
        send_whole();
        // lldp header cut short, then lldp with nothing after it
        fill_mode = FILL_ZERO;
        add_eth(ETYPE_LLDP);
        add_fill(1);
        send_whole();
        add_eth(ETYPE_LLDP);
        add_fill(int'(LLDP_LEN));
        send_whole();
        // ipv4 carrying something other than udp
        fill_mode = FILL_ONES;
        add_eth(ETYPE_IPV4);
        add_ipv4(PROTO_TCP);
        add_fill(4);
        send_whole();
        // ipv4 udp, all-zero and all-one contents
        fill_mode = FILL_ZERO;
        add_eth(ETYPE_IPV4);
        add_ipv4(PROTO_UDP);
        add_udp();
        send_whole();
        fill_mode = FILL_ONES;
        add_eth(ETYPE_IPV4);
        add_ipv4(PROTO_UDP);
        add_udp();
        add_fill(5);
        send_whole();
        // udp header cut in the middle
        fill_mode = FILL_RANDOM;
        add_eth(ETYPE_IPV4);
        add_ipv4(PROTO_UDP);
        add_udp();
        send_frame(int'(ETH_LEN) + int'(IPV4_LEN) + 3);
        // ipv6 with no next header
        fill_mode = FILL_ONES;
        add_eth(ETYPE_IPV6);
        add_ipv6(PROTO_NONE);
        add_fill(3);
        send_whole();
        // ipv6 udp ending right after the udp header
        add_eth(ETYPE_IPV6);
        add_ipv6(PROTO_UDP);
        add_udp();
        send_whole();
        // extension chain ending in udp
        fill_mode = FILL_RANDOM;
        add_eth(ETYPE_IPV6);
        add_ipv6(NH_HOP_BY_HOP);
        add_ext(NH_ROUTING, 8'd1);
        add_ext(PROTO_UDP, 8'd0);
        add_udp();
        add_fill(3);
        send_whole();
        // extension chain ending in no next header
        add_eth(ETYPE_IPV6);
        add_ipv6(NH_DEST_OPTS);
        add_ext(PROTO_NONE, 8'd0);
        add_fill(4);
        send_whole();

        drain();

        // random frames, one stretch with no idling on either side
        rand_bytes0  = bytes_sent;
        rand_frames0 = frames_sent;
        while (bytes_sent - rand_bytes0 < RANDOM_BYTES
               || frames_sent - rand_frames0 < RANDOM_FRAMES) begin
            steady <= (frames_sent - rand_frames0 >= 6) && (frames_sent - rand_frames0 < 14);
            random_frame();
        end
        steady <= 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ethernet_ip_udp_header_parser_core: match");
        end else begin
            $display("ethernet_ip_udp_header_parser_core: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/eiuhp_pkg.sv
rtl/ethernet_ip_udp_header_parser_core.sv
sim/eiuhp_result_checker.sv
sim/ethernet_ip_udp_header_parser_core_tb.sv
